[hdl/ghac_pkg.sv]
// ----------------------------------------------------------------------------
// ghac_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ghac_pkg;

    localparam int SLOTS  = 1024;
    localparam int IDX_W  = 20;                  // slot index field of a handle
    localparam int GEN_W  = 12;                  // generation field of a handle
    localparam int ADDR_W = $clog2(SLOTS);       // memory address, slot - 1
    localparam int CNT_W  = $clog2(SLOTS + 2);   // slot number 0..SLOTS+1

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CHECK = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NO_FREE = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] handle;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] new_handle;
        logic        is_valid;
    } rsp_t;

    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic             active;
    } slot_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        slot_entry_t       data;
    } slot_wr_t;

    typedef struct packed {
        logic             pop;
        logic             push;
        logic [CNT_W-1:0] push_slot;
    } stack_ctl_t;

endpackage

`default_nettype wire

[hdl/ghac_slot_store.sv]
// ----------------------------------------------------------------------------
// ghac_slot_store
// Per-slot generation and live flag, one synchronous read and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ghac_slot_store (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [ghac_pkg::ADDR_W-1:0] rd_addr,
    output ghac_pkg::slot_entry_t           rd_data,
    input  wire ghac_pkg::slot_wr_t         wr
);
    import ghac_pkg::*;

    // Entries at or above the fresh pointer are never written; the caller
    // treats them as zero, so no clearing pass is needed.
    slot_entry_t mem [SLOTS];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/ghac_free_stack.sv]
// ----------------------------------------------------------------------------
// ghac_free_stack
// LIFO of freed slot numbers held in a memory, with its fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module ghac_free_stack (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ghac_pkg::stack_ctl_t       ctl,
    output logic [ghac_pkg::CNT_W-1:0]      count,
    output logic [ghac_pkg::CNT_W-1:0]      rd_slot
);
    import ghac_pkg::*;

    logic [CNT_W-1:0] mem [SLOTS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] top_idx;
    logic [CNT_W-1:0] rd_slot_reg;

    assign top_idx = count_reg - CNT_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (ctl.pop)
        begin
            count_next = top_idx;
        end
        else if (ctl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // only entries below the count are ever read
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[count_reg[ADDR_W-1:0]] <= ctl.push_slot;
        end
        if (ctl.pop)
        begin
            rd_slot_reg <= mem[top_idx[ADDR_W-1:0]];
        end
    end

    assign count   = count_reg;
    assign rd_slot = rd_slot_reg;

endmodule

`default_nettype wire

[hdl/generational_handle_allocator_core.sv]
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Allocates, frees and checks 32-bit generational handles over SLOTS slots.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------
//  req     | in  | req_valid/req_ready  | command, handle {gen[31:20],idx[19:0]}
//  rsp     | out | rsp_valid/rsp_ready  | status, new_handle, is_valid
//
//  The result register loads from S_EXEC once the output register is free; an
//  allocate that pops the freed stack passes S_POP first (stack read, then
//  slot read). The next request is taken once the FSM is back in S_IDLE.
//  One transaction is in flight; the slot memory read-modify-write sets this.
//  Reset leaves both memories untouched: slots at or above the fresh pointer
//  read as generation 0 / not live, so there is no clearing pass.
//  A stalled result holds in the output register while the next request is
//  taken; only the write-back stage waits for the register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_allocator_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire ghac_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output ghac_pkg::rsp_t      rsp
);
    import ghac_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,      // stack read data returned, issue slot read
        S_EXEC      // slot read data returned, write back and respond
    } state_t;

    localparam logic [IDX_W-CNT_W-1:0] IDX_PAD = '0;

    state_t           state_reg, state_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [GEN_W-1:0] gen_reg, gen_next;       // generation from the request
    logic [CNT_W-1:0] slot_reg, slot_next;     // slot number being worked on
    logic             ok_reg, ok_next;         // slot in range / one available
    logic             seen_reg, seen_next;     // slot below the fresh pointer
    logic             pop_reg, pop_next;       // allocate came from the stack
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             slot_rd_en;
    logic [ADDR_W-1:0] slot_rd_addr;
    slot_entry_t      slot_rd;
    slot_wr_t         slot_wr;
    stack_ctl_t       stk_ctl;
    logic [CNT_W-1:0] stk_count;
    logic [CNT_W-1:0] stk_slot;

    logic [IDX_W-1:0] req_idx;
    logic             req_in_range;
    logic             req_seen;
    logic [GEN_W-1:0] gen_eff;
    logic             live;
    logic             out_free;

    ghac_slot_store u_slot_store (
        .clk     (clk),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd),
        .wr      (slot_wr)
    );

    ghac_free_stack u_free_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (stk_ctl),
        .count   (stk_count),
        .rd_slot (stk_slot)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign req_idx      = req.handle[IDX_W-1:0];
    assign req_in_range = (req_idx != '0) && (req_idx <= IDX_W'(SLOTS));
    assign req_seen     = req_idx < {IDX_PAD, fresh_reg};

    // Never-written entries read as zero via the fresh pointer
    assign gen_eff  = seen_reg ? slot_rd.gen : '0;
    assign live     = ok_reg && seen_reg && slot_rd.active && (slot_rd.gen == gen_reg);
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        gen_next       = gen_reg;
        slot_next      = slot_reg;
        ok_next        = ok_reg;
        seen_next      = seen_reg;
        pop_next       = pop_reg;
        fresh_next     = fresh_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        slot_rd_en     = 1'b0;
        slot_rd_addr   = '0;
        slot_wr        = '0;
        stk_ctl        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.command;
                    gen_next   = req.handle[IDX_W +: GEN_W];
                    pop_next   = 1'b0;
                    state_next = S_EXEC;
                    case (req.command)
                        CMD_ALLOC:
                        begin
                            if (stk_count != '0)
                            begin
                                stk_ctl.pop = 1'b1;
                                pop_next    = 1'b1;
                                state_next  = S_POP;
                            end
                            else
                            begin
                                slot_next    = fresh_reg;
                                ok_next      = fresh_reg <= CNT_W'(SLOTS);
                                seen_next    = 1'b0;
                                slot_rd_en   = ok_next;
                                slot_rd_addr = ADDR_W'(fresh_reg - CNT_W'(1));
                            end
                        end
                        CMD_FREE, CMD_CHECK:
                        begin
                            slot_next    = req_idx[CNT_W-1:0];
                            ok_next      = req_in_range;
                            seen_next    = req_seen;
                            slot_rd_en   = req_in_range;
                            slot_rd_addr = ADDR_W'(req_idx - IDX_W'(1));
                        end
                        default:
                        begin
                            ok_next   = 1'b0;
                            seen_next = 1'b0;
                        end
                    endcase
                end
            end

            S_POP:
            begin
                slot_next    = stk_slot;
                ok_next      = 1'b1;
                seen_next    = 1'b1;
                slot_rd_en   = 1'b1;
                slot_rd_addr = ADDR_W'(stk_slot - CNT_W'(1));
                state_next   = S_EXEC;
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    slot_wr.addr   = ADDR_W'(slot_reg - CNT_W'(1));
                    state_next     = S_IDLE;
                    case (cmd_reg)
                        CMD_ALLOC:
                        begin
                            if (ok_reg)
                            begin
                                rsp_next.status     = ST_OK;
                                rsp_next.new_handle = {gen_eff, IDX_PAD, slot_reg};
                                slot_wr.en          = 1'b1;
                                slot_wr.data.gen    = gen_eff;
                                slot_wr.data.active = 1'b1;
                                if (!pop_reg)
                                begin
                                    fresh_next = fresh_reg + CNT_W'(1);
                                end
                            end
                            else
                            begin
                                rsp_next.status = ST_NO_FREE;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (live)
                            begin
                                rsp_next.status     = ST_OK;
                                rsp_next.is_valid   = 1'b1;
                                slot_wr.en          = 1'b1;
                                slot_wr.data.gen    = slot_rd.gen + GEN_W'(1);
                                slot_wr.data.active = 1'b0;
                                stk_ctl.push        = stk_count < CNT_W'(SLOTS);
                                stk_ctl.push_slot   = slot_reg;
                            end
                            else
                            begin
                                rsp_next.status = ST_INVALID;
                            end
                        end
                        CMD_CHECK:
                        begin
                            rsp_next.status   = ST_OK;
                            rsp_next.is_valid = live;
                        end
                        default:
                        begin
                            rsp_next.status = ST_INVALID;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            gen_reg       <= '0;
            slot_reg      <= '0;
            ok_reg        <= 1'b0;
            seen_reg      <= 1'b0;
            pop_reg       <= 1'b0;
            fresh_reg     <= CNT_W'(1);
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            gen_reg       <= gen_next;
            slot_reg      <= slot_next;
            ok_reg        <= ok_next;
            seen_reg      <= seen_next;
            pop_reg       <= pop_next;
            fresh_reg     <= fresh_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stk_ctl.pop |-> stk_count != '0)
        else $error("pop from empty freed stack");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        stk_ctl.push |-> stk_count < CNT_W'(SLOTS))
        else $error("push onto full freed stack");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= CNT_W'(SLOTS + 1))
        else $error("fresh pointer beyond slot range");

    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("response raised outside write-back");

    a_write_below_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        slot_wr.en |-> (slot_reg != '0) && (slot_reg <= fresh_reg))
        else $error("slot write outside the used range");
`endif

endmodule

`default_nettype wire
